// ===== src/asgr_pkg.sv =====
// Shared types, constants and helper functions of the ANSI SGR color parser.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package asgr_pkg;

	// Field widths
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 4;
	localparam int MODE_W  = 3;

	// Attributes applied per sequence, and the counter that saturates there
	localparam int MAX_ATTRS = 5;
	localparam int ATTR_W    = $clog2(MAX_ATTRS + 1);

	// Parser modes
	localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ESC   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FIRST = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LIST  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SKIP  = 3'd4;

	// Byte codes
	localparam logic [CHAR_W-1:0] BYTE_ESC      = 8'h1B;
	localparam logic [CHAR_W-1:0] BYTE_LBRACKET = 8'h5B;
	localparam logic [CHAR_W-1:0] BYTE_SEMI     = 8'h3B;
	localparam logic [CHAR_W-1:0] BYTE_M        = 8'h6D;
	localparam logic [CHAR_W-1:0] BYTE_S        = 8'h73;
	localparam logic [CHAR_W-1:0] BYTE_U        = 8'h75;
	localparam logic [CHAR_W-1:0] BYTE_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0] BYTE_NINE     = 8'h39;
	localparam logic [CHAR_W-1:0] CODE_MAX      = 8'hFF;

	// Colors
	localparam logic [COLOR_W-1:0] VGA_BLACK  = 4'd0;
	localparam logic [COLOR_W-1:0] COLOR_GREY = 4'd7;
	localparam logic [COLOR_W-1:0] VGA_WHITE  = 4'd15;
	localparam logic [COLOR_W-1:0] BRIGHT_BIT = 4'd8;

	// Event kinds
	localparam logic KIND_CHAR  = 1'b0;
	localparam logic KIND_COLOR = 1'b1;

	// SGR attribute codes
	localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'd0;
	localparam logic [CHAR_W-1:0] ATTR_SWAP    = 8'd7;
	localparam logic [CHAR_W-1:0] ATTR_HIDE    = 8'd8;
	localparam logic [CHAR_W-1:0] ATTR_FG_LO   = 8'd30;
	localparam logic [CHAR_W-1:0] ATTR_FG_HI   = 8'd37;
	localparam logic [CHAR_W-1:0] ATTR_BG_LO   = 8'd40;
	localparam logic [CHAR_W-1:0] ATTR_BG_HI   = 8'd47;
	localparam logic [CHAR_W-1:0] ATTR_BFG_LO  = 8'd90;
	localparam logic [CHAR_W-1:0] ATTR_BFG_HI  = 8'd97;
	localparam logic [CHAR_W-1:0] ATTR_BBG_LO  = 8'd100;
	localparam logic [CHAR_W-1:0] ATTR_BBG_HI  = 8'd107;

	typedef struct packed {
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
	} color_pair_t;

	typedef struct packed {
		logic               event_kind;
		logic [CHAR_W-1:0]  char_code;
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
		logic               last_of_run;
	} result_t;

	// Map an ANSI color index to its VGA palette index
	function automatic logic [COLOR_W-1:0] vga_of_ansi(input logic [2:0] idx);
		logic [COLOR_W-1:0] v;
		case (idx)
			3'd0: v = 4'd0;
			3'd1: v = 4'd4;
			3'd2: v = 4'd2;
			3'd3: v = 4'd6;
			3'd4: v = 4'd1;
			3'd5: v = 4'd5;
			3'd6: v = 4'd3;
			3'd7: v = 4'd7;
			default: v = 4'd0;
		endcase
		return v;
	endfunction

	// Apply one SGR attribute to a pending color pair
	function automatic color_pair_t apply_attr(input logic [CHAR_W-1:0] a,
			input color_pair_t p);
		color_pair_t r;
		logic [CHAR_W-1:0] off;
		r   = p;
		off = '0;
		if (a == ATTR_RESET) begin
			r.fg = COLOR_GREY;
			r.bg = VGA_BLACK;
		end else if (a == ATTR_SWAP) begin
			r.fg = p.bg;
			r.bg = p.fg;
		end else if (a == ATTR_HIDE) begin
			r.fg = p.bg;
		end else if (a >= ATTR_FG_LO && a <= ATTR_FG_HI) begin
			off  = a - ATTR_FG_LO;
			r.fg = vga_of_ansi(off[2:0]);
		end else if (a >= ATTR_BFG_LO && a <= ATTR_BFG_HI) begin
			off  = a - ATTR_BFG_LO;
			r.fg = vga_of_ansi(off[2:0]) | BRIGHT_BIT;
		end else if (a >= ATTR_BG_LO && a <= ATTR_BG_HI) begin
			off  = a - ATTR_BG_LO;
			r.bg = vga_of_ansi(off[2:0]);
		end else if (a >= ATTR_BBG_LO && a <= ATTR_BBG_HI) begin
			off  = a - ATTR_BBG_LO;
			r.bg = vga_of_ansi(off[2:0]) | BRIGHT_BIT;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/asgr_in_if.sv =====
// Input channel of the ANSI SGR color parser: one text byte per item.
// Depends on asgr_pkg for field widths.
`default_nettype none

interface asgr_in_if import asgr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] byte_value;
	logic              first_of_string;

	modport source (output valid, output byte_value, output first_of_string, input ready);
	modport sink   (input valid, input byte_value, input first_of_string, output ready);
endinterface

`default_nettype wire

// ===== src/asgr_out_if.sv =====
// Output channel of the ANSI SGR color parser: one draw or color event per item.
// Depends on asgr_pkg for field widths.
`default_nettype none

interface asgr_out_if import asgr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               event_kind;
	logic [CHAR_W-1:0]  char_code;
	logic [COLOR_W-1:0] fg_color;
	logic [COLOR_W-1:0] bg_color;
	logic               last_of_run;

	modport source (output valid, output event_kind, output char_code, output fg_color,
		output bg_color, output last_of_run, input ready);
	modport sink   (input valid, input event_kind, input char_code, input fg_color,
		input bg_color, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/ansi_sgr_color_parser.sv =====
// Top level of the ANSI SGR color parser: byte decode and result buffer.
// Depends on asgr_pkg, asgr_in_if and asgr_out_if.
`default_nettype none

// Accepts one text byte per clock, when the buffer has room, and emits
// draw-character and colors-changed events. Each byte is decoded in the cycle
// it is accepted; its events (zero to three) land in a three-entry result
// buffer that, while the output is ready, drains one event per cycle and so
// lets a stream with at most one event per byte run at one byte per clock. A
// new byte is taken when the buffer is empty or its last event leaves in the
// same cycle. Events reach the output the cycle after their byte is accepted.
module ansi_sgr_color_parser import asgr_pkg::*; (
	input  wire            clk,
	input  wire            arst_n,
	asgr_in_if.sink        text,
	asgr_out_if.source     events
);

	// Parser state
	logic [MODE_W-1:0]  mode_q;
	logic [CHAR_W-1:0]  accum_q;
	logic [ATTR_W-1:0]  attrs_q;
	color_pair_t        cur_q;
	color_pair_t        pend_q;

	// Result buffer
	result_t            res_q [3];
	logic [1:0]         res_cnt_q;

	// Decode outputs
	logic [MODE_W-1:0]  mode_d;
	logic [CHAR_W-1:0]  accum_d;
	logic [ATTR_W-1:0]  attrs_d;
	color_pair_t        cur_d;
	color_pair_t        pend_d;
	result_t            res_d [3];
	logic [1:0]         res_n_d;

	logic [CHAR_W-1:0]  b;
	logic               is_digit;
	logic [11:0]        digit_sum;
	logic [CHAR_W-1:0]  accum_next;
	logic               accept;
	logic               pop;

	function automatic result_t make_result(input logic kind, input logic [CHAR_W-1:0] ch,
			input color_pair_t c);
		result_t r;
		r.event_kind  = kind;
		r.char_code   = ch;
		r.fg_color    = c.fg;
		r.bg_color    = c.bg;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	// Handshake
	assign pop          = events.valid && events.ready;
	assign text.ready   = (res_cnt_q == 2'd0) || (res_cnt_q == 2'd1 && events.ready);
	assign accept       = text.valid && text.ready;

	assign events.valid       = (res_cnt_q != 2'd0);
	assign events.event_kind  = res_q[0].event_kind;
	assign events.char_code   = res_q[0].char_code;
	assign events.fg_color    = res_q[0].fg_color;
	assign events.bg_color    = res_q[0].bg_color;
	assign events.last_of_run = res_q[0].last_of_run;

	// Decimal accumulate with saturation; digits only matter inside a sequence,
	// where the stored code is the one in force
	assign b          = text.byte_value;
	assign is_digit   = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
	assign digit_sum  = 12'(accum_q) * 12'd10 + 12'(b - BYTE_ZERO);

	always_comb begin
		if (digit_sum > 12'(CODE_MAX)) begin
			accum_next = CODE_MAX;
		end else begin
			accum_next = digit_sum[CHAR_W-1:0];
		end
	end

	// Decode one byte: next state and the events it causes
	always_comb begin
		mode_d  = mode_q;
		accum_d = accum_q;
		attrs_d = attrs_q;
		cur_d   = cur_q;
		pend_d  = pend_q;
		res_n_d = 2'd0;
		for (int i = 0; i < 3; i++) begin
			res_d[i] = '0;
		end

		// New string: flush a pending escape, then report the reset colors
		if (text.first_of_string) begin
			if (mode_q == MODE_ESC) begin
				res_d[res_n_d] = make_result(KIND_CHAR, BYTE_ESC, cur_q);
				res_n_d        = res_n_d + 2'd1;
			end
			mode_d  = MODE_IDLE;
			accum_d = '0;
			attrs_d = '0;
			cur_d   = '{fg: VGA_WHITE, bg: VGA_BLACK};
			pend_d  = '{fg: VGA_WHITE, bg: VGA_BLACK};
			res_d[res_n_d] = make_result(KIND_COLOR, '0, cur_d);
			res_n_d        = res_n_d + 2'd1;
		end

		case (mode_d)
			MODE_ESC: begin
				if (b == BYTE_LBRACKET) begin
					mode_d  = MODE_FIRST;
					accum_d = '0;
					attrs_d = '0;
					pend_d  = cur_d;
				end else begin
					// Lone escape: draw it, then treat the byte as in idle
					res_d[res_n_d] = make_result(KIND_CHAR, BYTE_ESC, cur_d);
					res_n_d        = res_n_d + 2'd1;
					if (b == BYTE_ESC) begin
						mode_d = MODE_ESC;
					end else begin
						mode_d         = MODE_IDLE;
						res_d[res_n_d] = make_result(KIND_CHAR, b, cur_d);
						res_n_d        = res_n_d + 2'd1;
					end
				end
			end
			MODE_FIRST, MODE_LIST: begin
				if (is_digit) begin
					accum_d = accum_next;
				end else if (b == BYTE_SEMI || b == BYTE_M) begin
					// Apply the code unless the attribute count is used up
					if (attrs_d < ATTR_W'(MAX_ATTRS)) begin
						pend_d  = apply_attr(accum_d, pend_d);
						attrs_d = attrs_d + ATTR_W'(1);
					end
					accum_d = '0;
					if (b == BYTE_M) begin
						cur_d          = pend_d;
						mode_d         = MODE_IDLE;
						res_d[res_n_d] = make_result(KIND_COLOR, '0, cur_d);
						res_n_d        = res_n_d + 2'd1;
					end else begin
						mode_d = MODE_LIST;
					end
				end else if (mode_d == MODE_FIRST) begin
					if (b == BYTE_S || b == BYTE_U) begin
						mode_d = MODE_IDLE;
					end else begin
						mode_d = MODE_SKIP;
					end
				end
			end
			MODE_SKIP: begin
				if (b == BYTE_M) begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				if (b == BYTE_ESC) begin
					mode_d = MODE_ESC;
				end else begin
					mode_d         = MODE_IDLE;
					res_d[res_n_d] = make_result(KIND_CHAR, b, cur_d);
					res_n_d        = res_n_d + 2'd1;
				end
			end
		endcase

		// Mark the last event of this byte
		for (int i = 0; i < 3; i++) begin
			res_d[i].last_of_run = (2'(i) == res_n_d - 2'd1);
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			accum_q <= '0;
			attrs_q <= '0;
			cur_q   <= '{fg: VGA_WHITE, bg: VGA_BLACK};
			pend_q  <= '{fg: VGA_WHITE, bg: VGA_BLACK};
		end else if (accept) begin
			mode_q  <= mode_d;
			accum_q <= accum_d;
			attrs_q <= attrs_d;
			cur_q   <= cur_d;
			pend_q  <= pend_d;
		end
	end

	// Result buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
		end else if (accept) begin
			res_cnt_q <= res_n_d;
		end else if (pop) begin
			res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	// Result buffer payload: load a new batch or advance by one
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q[0] <= res_d[0];
			res_q[1] <= res_d[1];
			res_q[2] <= res_d[2];
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

`default_nettype wire
